// File: rtl/triggered_trace_ring_buffer_macros.svh
// Assertion macros shared by the trace buffer modules.
// Each macro expands to one labeled concurrent assertion that is
// disabled while the synchronous reset is held.
`ifndef TRIGGERED_TRACE_RING_BUFFER_MACROS_SVH
`define TRIGGERED_TRACE_RING_BUFFER_MACROS_SVH

// Same-cycle implication.
`define TTRB_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TTRB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ttrb_pkg.sv
// ----------------------------------------------------------------------------
// ttrb_pkg: shared types and constants of the triggered trace ring buffer.
// Holds the payload structs, the mode, status and register codes, and the
// command and status structs between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ttrb_pkg;

  // Default sizes for the top-level parameters.
  localparam int unsigned ENTRIES_DEF  = 64;
  localparam int unsigned ARG_BITS_DEF = 32;

  // Configuration port widths.
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 32;

  // Live trace mode.
  typedef enum logic [1:0] {
    MODE_OFF      = 2'd0,
    MODE_CIRCULAR = 2'd1,
    MODE_TRIGGER  = 2'd2,
    MODE_CAPTURE  = 2'd3
  } mode_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_STORED     = 3'd0,
    ST_NOT_STORED = 3'd1,
    ST_READ_ENTRY = 3'd2,
    ST_READ_EMPTY = 3'd3,
    ST_READ_REFUSED = 3'd4
  } status_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOG_MASK      = 4'd0,
    REG_MODE_REQUEST  = 4'd1,
    REG_TRIGGER_EVENT = 4'd2,
    REG_TRIGGER_MASK  = 4'd3,
    REG_TRIGGER_ARG0  = 4'd4,
    REG_TRIGGER_ARG1  = 4'd5,
    REG_TRIGGER_ARG2  = 4'd6,
    REG_TRIGGER_ARG3  = 4'd7
  } reg_idx_t;

  // Input item function codes.
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  // One input beat.
  typedef struct packed {
    logic               func;
    logic [15:0]        event_code;
    logic [2:0]         severity;
    logic [31:0]        stamp_seconds;
    logic signed [31:0] value0;
    logic signed [31:0] value1;
    logic signed [31:0] value2;
    logic signed [31:0] value3;
  } in_item_t;

  // One result beat.
  typedef struct packed {
    logic [2:0]         status;
    logic [31:0]        seq_number;
    logic [31:0]        entry_seconds;
    logic [15:0]        entry_code;
    logic [2:0]         entry_severity;
    logic signed [31:0] entry_arg0;
    logic signed [31:0] entry_arg1;
    logic signed [31:0] entry_arg2;
    logic signed [31:0] entry_arg3;
    logic [1:0]         mode_now;
  } out_item_t;

  // Controller state, one-hot.
  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_EXEC  = 3'b010,
    S_RDATA = 3'b100
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic capture;   // latch the accepted input beat
    logic do_write;  // execute a write event and load its result
    logic rd_issue;  // read the ring at the cursor and advance it
    logic rd_empty;  // load an empty or refused read result
    logic rd_load;   // load the result of an issued read
  } ctrl_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic is_write;  // held item is a write event
    logic rd_avail;  // mode is off and an unread entry exists
    logic out_free;  // result register can take a new beat
  } dp_status_t;

endpackage

`default_nettype wire

// File: rtl/ttrb_ctrl.sv
// ----------------------------------------------------------------------------
// ttrb_ctrl: sequencer of the trace buffer.
// Accepts one input beat at a time, steps it through execution and, for
// reads, through the registered memory access.
// ----------------------------------------------------------------------------
`default_nettype none
`include "triggered_trace_ring_buffer_macros.svh"

module ttrb_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  output logic                     cfg_ready,
  input  wire ttrb_pkg::dp_status_t sts,
  output ttrb_pkg::ctrl_cmd_t      cmd
);
  import ttrb_pkg::*;

  state_t state_r, state_nxt;
  logic   accept;

  // Input and configuration are taken only between items.
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign accept    = in_valid && !in_stall;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.is_write) begin
          if (sts.out_free) begin
            cmd.do_write = 1'b1;
            state_nxt    = S_IDLE;
          end
        end else if (sts.rd_avail) begin
          cmd.rd_issue = 1'b1;
          state_nxt    = S_RDATA;
        end else if (sts.out_free) begin
          cmd.rd_empty = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_RDATA: begin
        if (sts.out_free) begin
          cmd.rd_load = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // An accepted beat always moves on to execution.
  `TTRB_ASSERT_NEXT(a_accept_exec, clk, rst_n, accept, state_r == S_EXEC, "accept not followed by exec")
  // Read data is waited for only after a read was issued.
  `TTRB_ASSERT_IMPL(a_rdata_origin, clk, rst_n, state_r == S_RDATA, $past(state_r) == S_EXEC || $past(state_r) == S_RDATA, "read data state entered without issue")

endmodule

`default_nettype wire

// File: rtl/ttrb_dp.sv
// ----------------------------------------------------------------------------
// ttrb_dp: datapath of the trace buffer.
// Holds the configuration registers, ring pointers, sequence counter, the
// entry memory and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "triggered_trace_ring_buffer_macros.svh"

module ttrb_dp #(
  parameter int unsigned ENTRIES  = ttrb_pkg::ENTRIES_DEF,
  parameter int unsigned ARG_BITS = ttrb_pkg::ARG_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire ttrb_pkg::in_item_t               in_data,
  output ttrb_pkg::out_item_t                   out_data,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  input  wire logic                             cfg_we,
  input  wire logic [ttrb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ttrb_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire ttrb_pkg::ctrl_cmd_t              cmd,
  output ttrb_pkg::dp_status_t                  sts
);
  import ttrb_pkg::*;

  localparam int unsigned PTR_W = $clog2(ENTRIES);
  localparam int unsigned ROW_W = 32 + 32 + 3 + 16 + 4 * ARG_BITS;
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(ENTRIES - 1);

  // Wrapping pointer increment; the depth need not be a power of two.
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == LAST_PTR) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  // Configuration registers.
  logic [7:0]          log_mask_r;
  logic [23:0]         trig_event_r;
  logic [3:0]          trig_mask_r;
  logic [ARG_BITS-1:0] trig_arg_r [4];

  // Control state.
  mode_t               live_r, live_nxt;
  logic [PTR_W-1:0]    head_r, head_nxt;
  logic [PTR_W-1:0]    tail_r, tail_nxt;
  logic [PTR_W-1:0]    cursor_r, cursor_nxt;
  logic [31:0]         seq_r, seq_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Payload registers.
  in_item_t            item_r;
  out_item_t           res_r, res_nxt;
  logic [ROW_W-1:0]    mem [ENTRIES];
  logic [ROW_W-1:0]    rd_row_r;

  // Working signals.
  logic [ARG_BITS-1:0] arg_in [4];
  logic [ARG_BITS-1:0] rd_arg [4];
  logic [3:0]          arg_hit;
  logic                id_hit;
  logic                trig_hit;
  logic                level_en;
  logic                do_store;
  mode_t               mode_after;
  logic [PTR_W-1:0]    tail_inc;
  logic [ROW_W-1:0]    wr_row;
  logic                mem_we;
  logic                res_load;

  // Arguments widened or cut to the stored width with sign extension.
  always_comb begin
    arg_in[0] = ARG_BITS'(item_r.value0);
    arg_in[1] = ARG_BITS'(item_r.value1);
    arg_in[2] = ARG_BITS'(item_r.value2);
    arg_in[3] = ARG_BITS'(item_r.value3);
  end

  // Trigger match: full id, and every masked argument.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      arg_hit[i] = !trig_mask_r[i] || (arg_in[i] == trig_arg_r[i]);
    end
  end
  assign id_hit   = (trig_event_r[23:19] == 5'd0) &&
                    (trig_event_r[18:16] == item_r.severity) &&
                    (trig_event_r[15:0] == item_r.event_code);
  assign trig_hit = id_hit && (&arg_hit);

  // Store decision for a write event.
  assign level_en   = log_mask_r[item_r.severity];
  assign do_store   = level_en && ((live_r == MODE_CIRCULAR) || (live_r == MODE_CAPTURE) ||
                                   ((live_r == MODE_TRIGGER) && trig_hit));
  assign mode_after = (live_r == MODE_TRIGGER) ? MODE_CAPTURE : live_r;
  assign tail_inc   = ptr_inc(tail_r);
  assign wr_row     = {seq_r, item_r.stamp_seconds, item_r.severity, item_r.event_code,
                       arg_in[0], arg_in[1], arg_in[2], arg_in[3]};

  // Fields of the row read back from the ring.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rd_arg[i] = rd_row_r[(3 - i) * ARG_BITS +: ARG_BITS];
    end
  end

  // Status toward the controller.
  assign sts.is_write = (item_r.func == FUNC_WRITE);
  assign sts.rd_avail = (live_r == MODE_OFF) && (cursor_r != tail_r);
  assign sts.out_free = !out_valid_r || !out_stall;

  // Next values of control state and of the result.
  always_comb begin
    live_nxt   = live_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    cursor_nxt = cursor_r;
    seq_nxt    = seq_r;
    res_nxt    = res_r;
    mem_we     = 1'b0;
    res_load   = 1'b0;

    // Mode register write; trigger also empties the ring, off rewinds the read cursor to the head.
    if (cfg_we && (cfg_index == REG_MODE_REQUEST)) begin
      live_nxt = mode_t'(cfg_data[1:0]);
      if (mode_t'(cfg_data[1:0]) == MODE_TRIGGER) begin
        head_nxt   = '0;
        tail_nxt   = '0;
        cursor_nxt = '0;
      end else if (mode_t'(cfg_data[1:0]) == MODE_OFF) begin
        cursor_nxt = head_r;
      end
    end

    // Write event.
    if (cmd.do_write) begin
      res_load       = 1'b1;
      res_nxt        = '0;
      res_nxt.status = ST_NOT_STORED;
      if (level_en) begin
        seq_nxt            = seq_r + 32'd1;
        res_nxt.seq_number = seq_r;
      end
      if (do_store) begin
        mem_we         = 1'b1;
        tail_nxt       = tail_inc;
        res_nxt.status = ST_STORED;
        if (mode_after == MODE_CAPTURE) begin
          live_nxt = MODE_CAPTURE;
          if (tail_inc == LAST_PTR) begin
            live_nxt   = MODE_OFF;
            cursor_nxt = head_r;
          end
        end else if (head_r == ptr_inc(tail_inc)) begin
          head_nxt = ptr_inc(head_r);
        end
      end
      res_nxt.mode_now = live_nxt;
    end

    // Read issue advances the cursor.
    if (cmd.rd_issue) begin
      cursor_nxt = ptr_inc(cursor_r);
    end

    // Read with nothing to return.
    if (cmd.rd_empty) begin
      res_load         = 1'b1;
      res_nxt          = '0;
      res_nxt.status   = (live_r != MODE_OFF) ? ST_READ_REFUSED : ST_READ_EMPTY;
      res_nxt.mode_now = live_r;
    end

    // Read with an entry from the ring.
    if (cmd.rd_load) begin
      res_load               = 1'b1;
      res_nxt.status         = ST_READ_ENTRY;
      res_nxt.seq_number     = rd_row_r[ROW_W-1 -: 32];
      res_nxt.entry_seconds  = rd_row_r[ROW_W-33 -: 32];
      res_nxt.entry_severity = rd_row_r[ROW_W-65 -: 3];
      res_nxt.entry_code     = rd_row_r[ROW_W-68 -: 16];
      res_nxt.entry_arg0     = 32'(rd_arg[0]);
      res_nxt.entry_arg1     = 32'(rd_arg[1]);
      res_nxt.entry_arg2     = 32'(rd_arg[2]);
      res_nxt.entry_arg3     = 32'(rd_arg[3]);
      res_nxt.mode_now       = live_r;
    end

    // Result register holds until the beat is taken.
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r       <= MODE_CIRCULAR;
      head_r       <= '0;
      tail_r       <= '0;
      cursor_r     <= '0;
      seq_r        <= '0;
      out_valid_r  <= 1'b0;
      log_mask_r   <= 8'hff;
      trig_event_r <= '0;
      trig_mask_r  <= '0;
      for (int i = 0; i < 4; i++) begin
        trig_arg_r[i] <= '0;
      end
    end else begin
      live_r      <= live_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cursor_r    <= cursor_nxt;
      seq_r       <= seq_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_LOG_MASK:      log_mask_r    <= cfg_data[7:0];
          REG_TRIGGER_EVENT: trig_event_r  <= cfg_data[23:0];
          REG_TRIGGER_MASK:  trig_mask_r   <= cfg_data[3:0];
          REG_TRIGGER_ARG0:  trig_arg_r[0] <= ARG_BITS'($signed(cfg_data[31:0]));
          REG_TRIGGER_ARG1:  trig_arg_r[1] <= ARG_BITS'($signed(cfg_data[31:0]));
          REG_TRIGGER_ARG2:  trig_arg_r[2] <= ARG_BITS'($signed(cfg_data[31:0]));
          REG_TRIGGER_ARG3:  trig_arg_r[3] <= ARG_BITS'($signed(cfg_data[31:0]));
          default: begin
          end
        endcase
      end
    end
  end

  // Input beat and result registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
    end
    res_r <= res_nxt;
  end

  // Entry memory: one write and one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[tail_r] <= wr_row;
    end
    if (cmd.rd_issue) begin
      rd_row_r <= mem[cursor_r];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = res_r;

  // A read is issued only while off and with an unread entry.
  `TTRB_ASSERT_IMPL(a_rd_issue_ok, clk, rst_n, cmd.rd_issue, live_r == MODE_OFF && cursor_r != tail_r, "read issued without an entry")
  // Every executed write produces a result beat.
  `TTRB_ASSERT_NEXT(a_write_result, clk, rst_n, cmd.do_write, out_valid_r, "write without result beat")

endmodule

`default_nettype wire

// File: rtl/triggered_trace_ring_buffer.sv
// A write or an empty read is executed in S_EXEC and its result registered; a read that
// returns an entry passes also through S_RDATA and the registered memory read. The
// controller steps one item at a time and takes a new one only once the last result is loaded.
// A result waiting on out_stall holds execution of the next item but not its acceptance.
// Reset (synchronous, rst_n low) restores the registers and pointers at once; the entry
// memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// triggered_trace_ring_buffer: trace buffer with trigger capture.
// Stores enabled events in a ring in circular, trigger or capture mode and
// returns stored entries on read while tracing is off.
// ----------------------------------------------------------------------------
`default_nettype none

module triggered_trace_ring_buffer #(
  parameter int unsigned ENTRIES  = ttrb_pkg::ENTRIES_DEF,
  parameter int unsigned ARG_BITS = ttrb_pkg::ARG_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire ttrb_pkg::in_item_t               in_data,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output ttrb_pkg::out_item_t                   out_data,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [ttrb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ttrb_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ttrb_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t sts;
  logic       cfg_we;

  // A configuration beat completes on valid and ready.
  assign cfg_we = cfg_valid && cfg_ready;

  // Sequencer.
  ttrb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cfg_ready (cfg_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Registers, ring memory and result.
  ttrb_dp #(
    .ENTRIES  (ENTRIES),
    .ARG_BITS (ARG_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

`default_nettype wire
